// ----- hw/rtl/brt_pkg.sv -----
// ----------------------------------------------------------------------------
// brt_pkg
// Shared types, opcodes and register map of the byte register timer.
// ----------------------------------------------------------------------------
package brt_pkg;

  localparam int NUM_REGS_DEF = 32;
  localparam int OP_W         = 2;
  localparam int IDX_W        = 6;
  localparam int DATA_W       = 8;
  localparam int CNT_W        = 24;

  // Operation codes
  localparam logic [OP_W-1:0] OP_READ  = 2'd0;
  localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK  = 2'd2;

  // Register map
  localparam logic [IDX_W-1:0] IDX_CTRL  = 6'd16;
  localparam logic [IDX_W-1:0] IDX_PRE_H = 6'd19;
  localparam logic [IDX_W-1:0] IDX_PRE_M = 6'd20;
  localparam logic [IDX_W-1:0] IDX_PRE_L = 6'd21;
  localparam logic [IDX_W-1:0] IDX_CNT_H = 6'd23;
  localparam logic [IDX_W-1:0] IDX_CNT_M = 6'd24;
  localparam logic [IDX_W-1:0] IDX_CNT_L = 6'd25;

  // Control register layout
  localparam int CTRL_EN_BIT   = 0;
  localparam int CTRL_ROLL_BIT = 4;
  localparam logic [DATA_W-1:0] CTRL_WR_MASK = 8'hF7;

  localparam logic [DATA_W-1:0] BAD_IDX_DATA = 8'hFF;
  localparam logic [DATA_W-1:0] REG_RST_ALT  = 8'h0F;
  localparam logic [CNT_W-1:0]  CNT_ALL_ONES = 24'hFFFFFF;

  typedef struct packed {
    logic              fire;
    logic [OP_W-1:0]   op;
    logic [IDX_W-1:0]  reg_index;
    logic [DATA_W-1:0] write_data;
  } req_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              timer_interrupt;
  } rsp_t;

  // Reset value of a general register entry
  function automatic logic [DATA_W-1:0] reg_rst_val(input int idx);
    return (idx == 5 || idx == 17) ? REG_RST_ALT : '0;
  endfunction

  // Output modes 5 and 7 raise the interrupt at terminal count
  function automatic logic irq_mode(input logic [DATA_W-1:0] ctrl);
    return (ctrl[7:5] == 3'd5) || (ctrl[7:5] == 3'd7);
  endfunction

endpackage

// ----- hw/rtl/brt_if.sv -----
// ----------------------------------------------------------------------------
// brt_if
// Valid/ready channel interfaces for bus items and timer results.
// ----------------------------------------------------------------------------
interface brt_in_if;
  logic                        valid;
  logic                        ready;
  logic [brt_pkg::OP_W-1:0]    op;
  logic [brt_pkg::IDX_W-1:0]   reg_index;
  logic [brt_pkg::DATA_W-1:0]  write_data;

  modport source (output valid, output op, output reg_index, output write_data,
                  input ready);
  modport sink   (input valid, input op, input reg_index, input write_data,
                  output ready);
endinterface

interface brt_out_if;
  logic                        valid;
  logic                        ready;
  logic [brt_pkg::DATA_W-1:0]  read_data;
  logic                        timer_interrupt;

  modport source (output valid, output read_data, output timer_interrupt,
                  input ready);
  modport sink   (input valid, input read_data, input timer_interrupt,
                  output ready);
endinterface

// ----- hw/rtl/byte_register_timer_24bit.sv -----
// ----------------------------------------------------------------------------
// byte_register_timer_24bit
// 24-bit interval timer behind a file of byte registers.
// ----------------------------------------------------------------------------
// Usage:
//  - in_ch carries one item per transfer: op (read, write, tick), reg_index
//    and write_data. out_ch returns exactly one result per item: read_data
//    (register byte on a read, else zero) and timer_interrupt (pulse).
//  - Registers 19..21 hold the preload and 23..25 the live count, high byte
//    first. Register 16 is timer control (bit 0 enable, bit 4 rollover,
//    bits 7..5 output mode). Indexes at or above NUM_REGS read 0xFF.
//  - Path: an input transfer is held in the input stage register, then
//    executed into the result register.
//  - Throughput: one item per cycle while out_ch is not stalled, set by the
//    single execute stage, which updates the register file and counter per fire.
//  - Stalls: when out_ready is low the result register holds, the input
//    stage holds its item, and in_ready drops only once both are full.
//  - Reset (rst_n low, synchronous): registers clear to zero except entries
//    5 and 17 (0x0F); count and preload clear; both stages empty.
// ----------------------------------------------------------------------------
module byte_register_timer_24bit #(
  parameter int NUM_REGS = brt_pkg::NUM_REGS_DEF
) (
  input logic      clk,
  input logic      rst_n,
  brt_in_if.sink   in_ch,
  brt_out_if.source out_ch
);

  // Input stage
  logic                        s1_valid_r;
  logic [brt_pkg::OP_W-1:0]    s1_op_r;
  logic [brt_pkg::IDX_W-1:0]   s1_idx_r;
  logic [brt_pkg::DATA_W-1:0]  s1_data_r;

  // Result stage
  logic                        out_valid_r;
  brt_pkg::rsp_t               out_rsp_r;

  logic                        exec_fire;
  brt_pkg::req_t               req;
  brt_pkg::rsp_t               rsp;

  // the execute stage moves when its item has somewhere to go
  assign exec_fire   = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || exec_fire;

  assign req.fire       = exec_fire;
  assign req.op         = s1_op_r;
  assign req.reg_index  = s1_idx_r;
  assign req.write_data = s1_data_r;

  brt_core #(
    .NUM_REGS (NUM_REGS)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
    if (in_ch.ready && in_ch.valid) begin
      s1_op_r   <= in_ch.op;
      s1_idx_r  <= in_ch.reg_index;
      s1_data_r <= in_ch.write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (exec_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
    if (exec_fire) begin
      out_rsp_r <= rsp;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.read_data       = out_rsp_r.read_data;
  assign out_ch.timer_interrupt = out_rsp_r.timer_interrupt;

  // a pending item in the input stage is never dropped while stalled
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !exec_fire |=> s1_valid_r) else $error("input item lost");

  // execute only fires into an empty or draining result register
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    exec_fire |-> !out_valid_r || out_ch.ready) else $error("result overrun");

endmodule

// ----- hw/rtl/brt_core.sv -----
// ----------------------------------------------------------------------------
// brt_core
// Register file, preload and count registers; executes one item per fire.
// ----------------------------------------------------------------------------
module brt_core #(
  parameter int NUM_REGS = brt_pkg::NUM_REGS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  brt_pkg::req_t req,
  output brt_pkg::rsp_t rsp
);

  localparam int AW = $clog2(NUM_REGS);

  logic [brt_pkg::DATA_W-1:0] regs_r [NUM_REGS];
  logic [brt_pkg::CNT_W-1:0]  count_r, count_nxt;
  logic [brt_pkg::CNT_W-1:0]  reload_r, reload_nxt;

  logic [brt_pkg::DATA_W-1:0] ctrl;
  logic                       idx_ok;
  logic [AW-1:0]              addr;
  logic                       reg_we;
  logic [brt_pkg::DATA_W-1:0] reg_wdata;
  logic [brt_pkg::CNT_W-1:0]  load_val;
  logic [brt_pkg::DATA_W-1:0] wd;

  assign ctrl   = regs_r[AW'(brt_pkg::IDX_CTRL)];
  assign idx_ok = req.reg_index < brt_pkg::IDX_W'(NUM_REGS);
  assign addr   = req.reg_index[AW-1:0];
  assign wd     = req.write_data;

  always_comb begin
    count_nxt  = count_r;
    reload_nxt = reload_r;
    reg_we     = 1'b0;
    reg_wdata  = wd;
    rsp        = '0;
    load_val   = (count_r == '0) ?
                 (ctrl[brt_pkg::CTRL_ROLL_BIT] ? brt_pkg::CNT_ALL_ONES : reload_r) :
                 count_r;
    unique case (req.op)
      brt_pkg::OP_READ: begin
        if (!idx_ok) begin
          rsp.read_data = brt_pkg::BAD_IDX_DATA;
        end else begin
          unique case (req.reg_index)
            brt_pkg::IDX_PRE_H: rsp.read_data = reload_r[23:16];
            brt_pkg::IDX_PRE_M: rsp.read_data = reload_r[15:8];
            brt_pkg::IDX_PRE_L: rsp.read_data = reload_r[7:0];
            brt_pkg::IDX_CNT_H: rsp.read_data = count_r[23:16];
            brt_pkg::IDX_CNT_M: rsp.read_data = count_r[15:8];
            brt_pkg::IDX_CNT_L: rsp.read_data = count_r[7:0];
            default:            rsp.read_data = regs_r[addr];
          endcase
        end
      end
      brt_pkg::OP_WRITE: begin
        if (idx_ok) begin
          unique case (req.reg_index)
            brt_pkg::IDX_CTRL: begin
              reg_we    = 1'b1;
              reg_wdata = wd & brt_pkg::CTRL_WR_MASK;
              // enable edge with an already expired count
              rsp.timer_interrupt = !ctrl[brt_pkg::CTRL_EN_BIT] &&
                                    wd[brt_pkg::CTRL_EN_BIT] &&
                                    (count_r == '0) && brt_pkg::irq_mode(wd);
            end
            brt_pkg::IDX_PRE_H: reload_nxt[23:16] = wd;
            brt_pkg::IDX_PRE_M: reload_nxt[15:8]  = wd;
            brt_pkg::IDX_PRE_L: reload_nxt[7:0]   = wd;
            brt_pkg::IDX_CNT_H: count_nxt[23:16]  = wd;
            brt_pkg::IDX_CNT_M: count_nxt[15:8]   = wd;
            brt_pkg::IDX_CNT_L: count_nxt[7:0]    = wd;
            default:            reg_we = 1'b1;
          endcase
        end
      end
      brt_pkg::OP_TICK: begin
        if (ctrl[brt_pkg::CTRL_EN_BIT]) begin
          count_nxt           = load_val - 1'b1;
          rsp.timer_interrupt = (count_nxt == '0) && brt_pkg::irq_mode(ctrl);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_REGS; i++) begin
      if (!rst_n) begin
        regs_r[i] <= brt_pkg::reg_rst_val(i);
      end else if (req.fire && reg_we && addr == AW'(i)) begin
        regs_r[i] <= reg_wdata;
      end
    end
    if (!rst_n) begin
      count_r  <= '0;
      reload_r <= '0;
    end else if (req.fire) begin
      count_r  <= count_nxt;
      reload_r <= reload_nxt;
    end
  end

  // control bit 3 never stores a one
  a_ctrl_bit3: assert property (@(posedge clk) disable iff (!rst_n)
    !ctrl[3]) else $error("ctrl bit 3 set");

  // a disabled timer does not count on a tick
  a_tick_off: assert property (@(posedge clk) disable iff (!rst_n)
    req.fire && req.op == brt_pkg::OP_TICK && !ctrl[brt_pkg::CTRL_EN_BIT]
    |=> $stable(count_r)) else $error("count moved while disabled");

  // reads never raise the interrupt, non-reads return zero data
  a_rsp_shape: assert property (@(posedge clk) disable iff (!rst_n)
    req.op != brt_pkg::OP_READ |-> rsp.read_data == '0)
    else $error("data on non-read");

  a_read_irq: assert property (@(posedge clk) disable iff (!rst_n)
    req.op == brt_pkg::OP_READ |-> !rsp.timer_interrupt)
    else $error("interrupt on read");

endmodule

// ----- dv/tb_byte_register_timer_24bit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_byte_register_timer_24bit
// Self-checking bench for the byte register timer: a short directed table of
// register accesses and timer ticks, then weighted random traffic in four
// flow-control phases. Each result is compared against a behavioral mirror
// of the register file and the 24-bit counter, or a typed-in pinned value.
// ----------------------------------------------------------------------------
module tb_byte_register_timer_24bit;
  import brt_pkg::*;

  localparam int N_REGS     = NUM_REGS_DEF;
  localparam int RA_W       = $clog2(N_REGS);
  localparam int N_PHASE    = 4;
  localparam int PHASE_ITEMS = 475;
  localparam int MAX_REPORT = 10;
  localparam int TAIL_CYCLES = 10;

  // Op 3 has no function in the block; it must return an all-zero result.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  // Indexes used by the directed table
  localparam logic [IDX_W-1:0] IDX_FIRST   = 6'd0;
  localparam logic [IDX_W-1:0] IDX_RST_A   = 6'd5;
  localparam logic [IDX_W-1:0] IDX_RST_B   = 6'd17;
  localparam logic [IDX_W-1:0] IDX_LAST    = 6'd31;
  localparam logic [IDX_W-1:0] IDX_BAD_LO  = 6'd32;
  localparam logic [IDX_W-1:0] IDX_BAD_TOP = 6'd63;

  // Slot of the control register in the mirror
  localparam logic [RA_W-1:0] CTRL_SLOT = RA_W'(IDX_CTRL);

  // Byte positions of the preload and live count
  localparam logic [IDX_W-1:0] TIMER_IDX [6] = '{IDX_PRE_H, IDX_PRE_M, IDX_PRE_L,
                                                 IDX_CNT_H, IDX_CNT_M, IDX_CNT_L};

  // Idle percentages per phase: none, sender only, receiver only, both
  localparam int SEND_IDLE [N_PHASE] = '{0, 86, 0, 33};
  localparam int RECV_STALL [N_PHASE] = '{0, 0, 86, 33};

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [IDX_W-1:0]  idx;
    logic [DATA_W-1:0] wd;
    logic              pinned;  // rsp below is typed in, not predicted
    rsp_t              rsp;
  } dir_row_t;

  localparam int N_DIR = 26;

  logic clk;
  logic rst_n;

  brt_in_if  in_ch ();
  brt_out_if out_ch ();

  byte_register_timer_24bit #(
    .NUM_REGS (N_REGS)
  ) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Mirror of the block state
  logic [DATA_W-1:0] mirror_regs [N_REGS];
  logic [CNT_W-1:0]  mirror_count;
  logic [CNT_W-1:0]  mirror_preload;

  // Results owed by the block, oldest first
  rsp_t reply_q [$];

  dir_row_t dir_rows [N_DIR];

  int send_idle_pct;
  int recv_stall_pct;
  int fail_cnt;
  int n_read, n_write, n_tick, n_unused;
  int n_checked, n_irq_seen;

  // --------------------------------------------------------------------------
  // Clock
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs a handshake
  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  // Interrupt condition: timer running, count at zero, output mode 5 or 7.
  function automatic logic count_hit_irq();
    logic [2:0] mode;
    mode = mirror_regs[CTRL_SLOT][7:5];
    return mirror_regs[CTRL_SLOT][CTRL_EN_BIT] && (mirror_count == '0) &&
           (mode == 3'd5 || mode == 3'd7);
  endfunction

  // Applies one bus item to the mirror and returns the result it owes.
  function automatic rsp_t apply_bus_item(input logic [OP_W-1:0] op,
                                          input logic [IDX_W-1:0] idx,
                                          input logic [DATA_W-1:0] wd);
    rsp_t r;
    logic was_on;
    r = '0;
    case (op)
      OP_READ: begin
        if (idx >= N_REGS) begin
          r.read_data = BAD_IDX_DATA;
        end else begin
          case (idx)
            IDX_PRE_H: r.read_data = mirror_preload[23:16];
            IDX_PRE_M: r.read_data = mirror_preload[15:8];
            IDX_PRE_L: r.read_data = mirror_preload[7:0];
            IDX_CNT_H: r.read_data = mirror_count[23:16];
            IDX_CNT_M: r.read_data = mirror_count[15:8];
            IDX_CNT_L: r.read_data = mirror_count[7:0];
            default:   r.read_data = mirror_regs[idx[RA_W-1:0]];
          endcase
        end
      end
      OP_WRITE: begin
        if (idx < N_REGS) begin
          case (idx)
            IDX_CTRL: begin
              // Only a 0 -> 1 enable edge looks for a zero count
              was_on = mirror_regs[CTRL_SLOT][CTRL_EN_BIT];
              mirror_regs[CTRL_SLOT] = wd & CTRL_WR_MASK;
              if (!was_on && wd[CTRL_EN_BIT]) r.timer_interrupt = count_hit_irq();
            end
            IDX_PRE_H: mirror_preload[23:16] = wd;
            IDX_PRE_M: mirror_preload[15:8]  = wd;
            IDX_PRE_L: mirror_preload[7:0]   = wd;
            IDX_CNT_H: mirror_count[23:16]   = wd;
            IDX_CNT_M: mirror_count[15:8]    = wd;
            IDX_CNT_L: mirror_count[7:0]     = wd;
            default:   mirror_regs[idx[RA_W-1:0]] = wd;
          endcase
        end
      end
      OP_TICK: begin
        if (mirror_regs[CTRL_SLOT][CTRL_EN_BIT]) begin
          // Zero count reloads first; a zero preload wraps straight to all ones
          if (mirror_count == '0) begin
            mirror_count = mirror_regs[CTRL_SLOT][CTRL_ROLL_BIT] ? CNT_ALL_ONES
                                                                  : mirror_preload;
          end
          mirror_count = mirror_count - 1'b1;
          r.timer_interrupt = count_hit_irq();
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Sender: one transfer per call, optional idle cycles in front of it.
  // valid stays high after a transfer; the next call either keeps it high or
  // drops it, so it never sees two assignments in one time step.
  // --------------------------------------------------------------------------
  task automatic push_item(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                           input logic [DATA_W-1:0] wd, input logic pinned,
                           input rsp_t pinned_rsp);
    rsp_t owed;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.op         <= op;
    in_ch.reg_index  <= idx;
    in_ch.write_data <= wd;
    do @(posedge clk); while (!in_ch.ready);
    // Transfer took place at this edge
    owed = apply_bus_item(op, idx, wd);
    if (pinned) owed = pinned_rsp;
    reply_q.push_back(owed);
    case (op)
      OP_READ:  n_read++;
      OP_WRITE: n_write++;
      OP_TICK:  n_tick++;
      default:  n_unused++;
    endcase
  endtask

  // Stop sending until every owed result has come back
  task automatic drain_replies();
    in_ch.valid <= 1'b0;
    while (reply_q.size() != 0) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Receiver: random back-pressure per phase
  // --------------------------------------------------------------------------
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic note_fail(input string what, input int exp_v, input int act_v);
    fail_cnt++;
    if (fail_cnt <= MAX_REPORT)
      $display("mismatch %s: expected 0x%0h got 0x%0h at %0t", what, exp_v, act_v, $realtime);
  endtask

  // --------------------------------------------------------------------------
  // Result checker: every transfer on out_ch is matched with the oldest
  // owed result, field by field
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    rsp_t owed;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (out_ch.timer_interrupt === 1'b1) n_irq_seen++;
      if (reply_q.size() == 0) begin
        note_fail("result with nothing owed, read_data", 0, out_ch.read_data);
      end else begin
        owed = reply_q.pop_front();
        n_checked++;
        if (out_ch.read_data !== owed.read_data)
          note_fail("read_data", owed.read_data, out_ch.read_data);
        if (out_ch.timer_interrupt !== owed.timer_interrupt)
          note_fail("timer_interrupt", owed.timer_interrupt, out_ch.timer_interrupt);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    logic [OP_W-1:0]   r_op;
    logic [IDX_W-1:0]  r_idx;
    logic [DATA_W-1:0] r_wd;
    int                pick;
    int                slot;

    fail_cnt       = 0;
    n_read         = 0;
    n_write        = 0;
    n_tick         = 0;
    n_unused       = 0;
    n_checked      = 0;
    n_irq_seen     = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;

    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.op         <= OP_READ;
    in_ch.reg_index  <= '0;
    in_ch.write_data <= '0;

    // Mirror reset: all zero except the two entries that come up as 0x0F
    for (int i = 0; i < N_REGS; i++) mirror_regs[i] = '0;
    mirror_regs[RA_W'(IDX_RST_A)] = REG_RST_ALT;
    mirror_regs[RA_W'(IDX_RST_B)] = REG_RST_ALT;
    mirror_count   = '0;
    mirror_preload = '0;

    // Directed table. Pinned rows carry a result read straight off the spec;
    // the rest are predicted.
    dir_rows = '{
      // reset values, first and last registers, out-of-range indexes
      '{OP_READ,   IDX_RST_A,   8'h00, 1'b1, '{REG_RST_ALT, 1'b0}},
      '{OP_READ,   IDX_RST_B,   8'h00, 1'b1, '{REG_RST_ALT, 1'b0}},
      '{OP_READ,   IDX_FIRST,   8'h00, 1'b1, '{8'h00, 1'b0}},
      '{OP_READ,   IDX_BAD_TOP, 8'h00, 1'b1, '{BAD_IDX_DATA, 1'b0}},
      '{OP_READ,   IDX_BAD_LO,  8'h00, 1'b1, '{BAD_IDX_DATA, 1'b0}},
      '{OP_WRITE,  IDX_BAD_TOP, 8'hAA, 1'b1, '{8'h00, 1'b0}},
      '{OP_WRITE,  IDX_LAST,    8'hFF, 1'b1, '{8'h00, 1'b0}},
      '{OP_READ,   IDX_LAST,    8'h00, 1'b1, '{8'hFF, 1'b0}},
      // tick while disabled, then the unused op
      '{OP_TICK,   IDX_FIRST,   8'h00, 1'b1, '{8'h00, 1'b0}},
      '{OP_UNUSED, IDX_BAD_TOP, 8'hFF, 1'b1, '{8'h00, 1'b0}},
      // enable edge on a zero count in mode 7; bit 3 never sticks
      '{OP_WRITE,  IDX_CTRL,    8'hFF, 1'b0, '{8'h00, 1'b0}},
      '{OP_READ,   IDX_CTRL,    8'h00, 1'b1, '{8'hF7, 1'b0}},
      // rollover mode reloads all ones
      '{OP_TICK,   IDX_FIRST,   8'h00, 1'b0, '{8'h00, 1'b0}},
      '{OP_WRITE,  IDX_CTRL,    8'h00, 1'b0, '{8'h00, 1'b0}},
      // preload 2, count 1, then mode 5 counting down to zero
      '{OP_WRITE,  IDX_PRE_L,   8'h02, 1'b0, '{8'h00, 1'b0}},
      '{OP_WRITE,  IDX_CNT_H,   8'h00, 1'b0, '{8'h00, 1'b0}},
      '{OP_WRITE,  IDX_CNT_M,   8'h00, 1'b0, '{8'h00, 1'b0}},
      '{OP_WRITE,  IDX_CNT_L,   8'h01, 1'b0, '{8'h00, 1'b0}},
      '{OP_WRITE,  IDX_CTRL,    8'hA1, 1'b0, '{8'h00, 1'b0}},
      '{OP_TICK,   IDX_FIRST,   8'h00, 1'b0, '{8'h00, 1'b0}},
      '{OP_TICK,   IDX_FIRST,   8'h00, 1'b0, '{8'h00, 1'b0}},
      '{OP_TICK,   IDX_FIRST,   8'h00, 1'b0, '{8'h00, 1'b0}},
      // rewrite while already enabled on a zero count: no pulse
      '{OP_WRITE,  IDX_CTRL,    8'hA1, 1'b0, '{8'h00, 1'b0}},
      // zero preload in reload mode wraps to all ones
      '{OP_WRITE,  IDX_PRE_L,   8'h00, 1'b0, '{8'h00, 1'b0}},
      '{OP_TICK,   IDX_FIRST,   8'h00, 1'b0, '{8'h00, 1'b0}},
      '{OP_READ,   IDX_CNT_H,   8'h00, 1'b0, '{8'h00, 1'b0}}
    };

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < N_DIR; i++)
      push_item(dir_rows[i].op, dir_rows[i].idx, dir_rows[i].wd,
                dir_rows[i].pinned, dir_rows[i].rsp);
    drain_replies();

    // Random traffic. Counts and preloads are kept mostly small so the timer
    // reaches zero often; control writes favor the interrupting modes.
    for (int ph = 0; ph < N_PHASE; ph++) begin
      send_idle_pct  = SEND_IDLE[ph];
      recv_stall_pct = RECV_STALL[ph];
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick  = $urandom_range(99);
        r_idx = IDX_W'($urandom_range(63));
        r_wd  = DATA_W'($urandom_range(255));
        if (pick < 35) begin
          r_op = OP_TICK;
        end else if (pick < 55) begin
          r_op = OP_READ;
          if ($urandom_range(9) < 7) r_idx = IDX_W'($urandom_range(N_REGS - 1));
        end else if (pick < 58) begin
          r_op = OP_UNUSED;
        end else begin
          r_op = OP_WRITE;
          pick = $urandom_range(99);
          if (pick < 25) begin
            r_idx = IDX_CTRL;
            if ($urandom_range(3) != 0) r_wd[7:5] = $urandom_range(1) ? 3'd5 : 3'd7;
            // rollover mode rarely, otherwise the count never gets back to zero
            if ($urandom_range(3) != 0) r_wd[CTRL_ROLL_BIT] = 1'b0;
          end else if (pick < 60) begin
            slot  = $urandom_range(5);
            r_idx = TIMER_IDX[slot];
            if ($urandom_range(3) != 0) begin
              if (r_idx == IDX_PRE_L || r_idx == IDX_CNT_L) r_wd = DATA_W'($urandom_range(7));
              else r_wd = '0;
            end
          end
        end
        push_item(r_op, r_idx, r_wd, 1'b0, '0);
      end
      // Sender holds off here until everything owed has come back
      drain_replies();
    end

    repeat (TAIL_CYCLES) @(posedge clk);

    $display("ran %0d reads, %0d writes, %0d ticks and %0d unused ops over four flow phases",
             n_read, n_write, n_tick, n_unused);
    $display("checked %0d results, %0d of them with the interrupt pulse, %0d failures",
             n_checked, n_irq_seen, fail_cnt);
    if (fail_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/brt_pkg.sv
hw/rtl/brt_if.sv
hw/rtl/brt_core.sv
hw/rtl/byte_register_timer_24bit.sv
dv/tb_byte_register_timer_24bit.sv
